/* rtl/assert_macros.svh */
// Assertion macros for the RTL that carries checks (the wake queue top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define OWQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define OWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OWQ_ASSERT_ALWAYS(lbl, expr, msg)
`define OWQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/owq_pkg.sv */
// Types and codes shared by the wake queue top level and its cells.
`timescale 1ns / 1ps
package owq_pkg;

  localparam int ID_W   = 16;
  localparam int WAKE_W = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } owq_status_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } owq_kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [WAKE_W-1:0] wake_time;
  } owq_entry_t;

  typedef struct packed {
    logic       cmp;
    logic       commit;
    owq_kind_t  kind;
    logic       mode;
    owq_entry_t req;
  } owq_ctrl_t;

endpackage

/* rtl/owq_cell.sv */
// One queue slot: compares against the request and shifts with its neighbors.
`timescale 1ns / 1ps
module owq_cell (
  input  logic               clk,
  input  owq_pkg::owq_ctrl_t ctrl,
  input  logic               valid,
  input  owq_pkg::owq_entry_t left,
  input  owq_pkg::owq_entry_t right,
  input  logic               ahead_in,
  output logic               ahead_out,
  output owq_pkg::owq_entry_t entry
);

  logic hit;
  logic hit_next;

  always_comb begin
    if (ctrl.kind == owq_pkg::KIND_INSERT) begin
      hit_next = !valid || (ctrl.mode && (entry.wake_time > ctrl.req.wake_time));
    end else begin
      hit_next = valid && (entry.id == ctrl.req.id);
    end
  end

  assign ahead_out = ahead_in | hit;

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      hit <= hit_next;
    end
    if (ctrl.commit) begin
      if (ctrl.kind == owq_pkg::KIND_INSERT) begin
        if (ahead_in) begin
          entry <= left;
        end else if (hit) begin
          entry <= ctrl.req;
        end
      end else if (ahead_in || hit) begin
        entry <= right;
      end
    end
  end

endmodule

/* rtl/ordered_wake_queue_top.sv */
// Flow: an accepted transfer moves through a compare state, which registers each slot's
// match, and an apply state, in which the slot row shifts and the result is registered;
// a stalled result holds the apply state, and no new transfer is accepted until it leaves.
// Reset: synchronous; the queue empties and FIFO mode is set at once, slot
// contents are left as they are and need no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ordered_wake_queue_top #(
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         cfg_we,
  input  logic                                         cfg_wdata,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // entry_id, wake_time
  input  logic [47:0]                                  s_tdata,
  // kind
  input  logic                                         s_tuser,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // status, result_id, entry_count, is_empty, is_full
  output logic [((20 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int OUT_W = ((20 + CNT_W + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  state_t                state;
  logic                  ordered_mode;
  logic [CNT_W-1:0]      occupancy;
  logic [CNT_W-1:0]      occupancy_next;
  owq_pkg::owq_kind_t    kind;
  owq_pkg::owq_entry_t   req;
  owq_pkg::owq_status_t  status_next;
  owq_pkg::owq_ctrl_t    ctrl;
  logic [OUT_W-1:0]      m_tdata_next;
  logic                  out_free;
  logic                  commit;
  logic [DEPTH:0]        ahead;
  owq_pkg::owq_entry_t   cells [DEPTH];

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    if (kind == owq_pkg::KIND_INSERT) begin
      status_next = (occupancy == DEPTH_C) ? owq_pkg::ST_FULL : owq_pkg::ST_OK;
    end else if (occupancy == '0) begin
      status_next = owq_pkg::ST_EMPTY;
    end else if (!ahead[DEPTH]) begin
      status_next = owq_pkg::ST_NOTFOUND;
    end else begin
      status_next = owq_pkg::ST_OK;
    end
  end

  assign commit = (state == S_APPLY) && out_free && (status_next == owq_pkg::ST_OK);

  always_comb begin
    occupancy_next = occupancy;
    if (status_next == owq_pkg::ST_OK) begin
      if (kind == owq_pkg::KIND_INSERT) begin
        occupancy_next = occupancy + CNT_W'(1);
      end else begin
        occupancy_next = occupancy - CNT_W'(1);
      end
    end
  end

  always_comb begin
    m_tdata_next = '0;
    m_tdata_next[1:0] = status_next;
    m_tdata_next[17:2] = req.id;
    m_tdata_next[18 +: CNT_W] = occupancy_next;
    m_tdata_next[18 + CNT_W] = (occupancy_next == '0);
    m_tdata_next[19 + CNT_W] = (occupancy_next == DEPTH_C);
  end

  assign ctrl.cmp    = (state == S_CMP);
  assign ctrl.commit = commit;
  assign ctrl.kind   = kind;
  assign ctrl.mode   = ordered_mode;
  assign ctrl.req    = req;

  assign ahead[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    owq_pkg::owq_entry_t left;
    owq_pkg::owq_entry_t right;

    if (i == 0) begin : g_head
      assign left = req;
    end else begin : g_body
      assign left = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = req;
    end else begin : g_inner
      assign right = cells[i+1];
    end

    owq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid     (IDX < occupancy),
      .left      (left),
      .right     (right),
      .ahead_in  (ahead[i]),
      .ahead_out (ahead[i+1]),
      .entry     (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ordered_mode <= 1'b0;
      occupancy    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        ordered_mode <= cfg_wdata;
      end
      if ((state == S_APPLY) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            kind          <= owq_pkg::owq_kind_t'(s_tuser);
            req.id        <= s_tdata[15:0];
            req.wake_time <= s_tdata[47:16];
            state         <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            occupancy <= occupancy_next;
            m_tdata   <= m_tdata_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `OWQ_ASSERT_ALWAYS(a_count_bound, occupancy <= DEPTH_C, "occupancy above depth")
  `OWQ_ASSERT_NEXT(a_commit_moves, commit, occupancy != $past(occupancy), "commit kept count")
  `OWQ_ASSERT_NEXT(a_fail_holds, (state == S_APPLY) && !commit, occupancy == $past(occupancy), "failed op changed count")
  `OWQ_ASSERT_ALWAYS(a_empty_flag, !m_tvalid || (m_tdata[18 + CNT_W] == (m_tdata[18 +: CNT_W] == '0)), "empty flag mismatch")

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the ordered wake queue: directed and randomized stream traffic, scoreboard.
`timescale 1ns / 1ps
module testbench;
  import owq_pkg::*;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RES_W = ((20 + CNT_W + 7) / 8) * 8;
  localparam int CNT_LO = 18;
  localparam int EMPTY_BIT = CNT_LO + CNT_W;
  localparam int FULL_BIT = EMPTY_BIT + 1;
  localparam int LIMIT = 600000;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 120;

  typedef struct packed {
    owq_kind_t kind;
    logic [ID_W-1:0] id;
    logic [WAKE_W-1:0] wake;
  } wake_request_t;

  typedef struct packed {
    owq_status_t status;
    logic [ID_W-1:0] id;
    logic [CNT_W-1:0] count;
    logic empty;
    logic full;
  } wake_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [RES_W-1:0] m_tdata;

  wake_request_t request_queue[$];
  wake_result_t expected_results[$];
  logic [ID_W-1:0] held_ids[$];
  logic [WAKE_W-1:0] held_times[$];
  bit ordered_mode;
  bit quiet;
  bit in_flight;
  wake_request_t cur;
  int send_gap;
  int recv_gap;
  int hold_left;
  int results_seen;
  int mismatches;
  int cycles;

  ordered_wake_queue_top #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic wake_result_t apply_request(owq_kind_t kind, logic [ID_W-1:0] id,
                                                 logic [WAKE_W-1:0] wake);
    wake_result_t r;
    int pos;
    r.id = id;
    r.status = ST_OK;
    if (kind == KIND_INSERT) begin
      if (held_ids.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = held_ids.size();
        if (ordered_mode) begin
          for (int i = 0; i < held_ids.size(); i++) begin
            if (held_times[i] > wake) begin
              pos = i;
              break;
            end
          end
        end
        held_ids.insert(pos, id);
        held_times.insert(pos, wake);
      end
    end else begin
      if (held_ids.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        pos = -1;
        for (int i = 0; i < held_ids.size(); i++) begin
          if (held_ids[i] == id) begin
            pos = i;
            break;
          end
        end
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          held_ids.delete(pos);
          held_times.delete(pos);
        end
      end
    end
    r.count = CNT_W'(held_ids.size());
    r.empty = (held_ids.size() == 0);
    r.full = (held_ids.size() >= DEPTH);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic add_request(input owq_kind_t kind, input logic [ID_W-1:0] id,
                             input logic [WAKE_W-1:0] wake);
    wake_request_t q;
    q.kind = kind;
    q.id = id;
    q.wake = wake;
    request_queue.push_back(q);
  endtask

  task automatic set_mode(input bit mode);
    while (request_queue.size() != 0 || in_flight || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    ordered_mode = mode;
    cfg_we <= 1'b0;
  endtask

  task automatic add_random_phase(input int count, input int insert_pct);
    logic [ID_W-1:0] id;
    logic [WAKE_W-1:0] wake;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70) id = ID_W'($urandom_range(0, 7));
      else if (r < 80) id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else id = ID_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 40) wake = $urandom_range(0, 15);
      else if (r < 50) wake = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      else wake = $urandom;
      add_request(($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE, id, wake);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_request(cur.kind, cur.id, cur.wake));
        in_flight = 1'b0;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          cur = request_queue.pop_front();
          in_flight = 1'b1;
          s_tvalid <= 1'b1;
          s_tdata <= {cur.wake, cur.id};
          s_tuser <= cur.kind;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    wake_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 0, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[1:0] !== want.status)
            report_mismatch("status", want.status, m_tdata[1:0]);
          if (m_tdata[17:2] !== want.id)
            report_mismatch("result_id", want.id, m_tdata[17:2]);
          if (m_tdata[CNT_LO +: CNT_W] !== want.count)
            report_mismatch("entry_count", want.count, m_tdata[CNT_LO +: CNT_W]);
          if (m_tdata[EMPTY_BIT] !== want.empty)
            report_mismatch("is_empty", want.empty, m_tdata[EMPTY_BIT]);
          if (m_tdata[FULL_BIT] !== want.full)
            report_mismatch("is_full", want.full, m_tdata[FULL_BIT]);
        end
        results_seen++;
        if (results_seen == 60 || results_seen == 520) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int pct_tab[PHASES];
    pct_tab = '{85, 25, 60, 90, 20, 55, 95, 30};
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    ordered_mode = 1'b0;
    quiet = 1'b0;
    in_flight = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    hold_left = 0;
    results_seen = 0;
    mismatches = 0;
    cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_mode(1'b0);
    add_request(KIND_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(KIND_INSERT, 16'h0000, 32'h0);
    add_request(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    add_request(KIND_INSERT, 16'h0000, 32'd5);
    add_request(KIND_REMOVE, 16'h1234, 32'h0);
    add_request(KIND_REMOVE, 16'h0000, 32'h0);
    add_request(KIND_REMOVE, 16'h0000, 32'h0);
    add_request(KIND_REMOVE, 16'h0000, 32'h0);
    add_request(KIND_REMOVE, 16'hFFFF, 32'h0);
    add_request(KIND_REMOVE, 16'h0000, 32'h0);

    set_mode(1'b1);
    add_request(KIND_INSERT, 16'd1, 32'd50);
    add_request(KIND_INSERT, 16'd2, 32'd10);
    add_request(KIND_INSERT, 16'd3, 32'd50);
    add_request(KIND_INSERT, 16'd4, 32'hFFFF_FFFF);
    add_request(KIND_INSERT, 16'd5, 32'h0);
    add_request(KIND_INSERT, 16'd3, 32'd10);
    add_request(KIND_REMOVE, 16'd3, 32'h0);

    set_mode(1'b0);
    add_request(KIND_INSERT, 16'd6, 32'd1);
    add_request(KIND_REMOVE, 16'd9, 32'h0);
    add_request(KIND_REMOVE, 16'd5, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      set_mode(p[0]);
      quiet = (p == 2 || p == 5);
      add_random_phase(PHASE_ITEMS, pct_tab[p]);
    end

    while (request_queue.size() != 0 || in_flight || expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/owq_pkg.sv
rtl/owq_cell.sv
rtl/ordered_wake_queue_top.sv
bench/testbench.sv
